FILE: hdl/flash_command_interface_defines.svh
// ----------------------------------------------------------------------------
// Flash command interface assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FLASH_COMMAND_INTERFACE_DEFINES_SVH
`define FLASH_COMMAND_INTERFACE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define FCI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define FCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fci_pkg.sv
// ----------------------------------------------------------------------------
// Flash command interface package
// Command phase and read mode codes, command bytes and the decode result type.
// ----------------------------------------------------------------------------
package fci_pkg;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Command sequencer phases
  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_UNLOCK1 = 9'b000000010,
    PH_UNLOCK2 = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_ERASE1  = 9'b000010000,
    PH_ERASE2  = 9'b000100000,
    PH_ERASE3  = 9'b001000000,
    PH_PROGRAM = 9'b010000000,
    PH_BANK    = 9'b100000000
  } phase_t;

  // What a read returns
  typedef enum logic [2:0] {
    RM_ARRAY  = 3'b001,
    RM_ID     = 3'b010,
    RM_ERASED = 3'b100
  } rmode_t;

  // Unlock sequence
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR1  = 16'h5555;
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR2  = 16'h2AAA;
  localparam logic [ADDR_W-1:0] BANK_SEL_ADDR = 16'h0000;
  localparam logic [DATA_W-1:0] UNLOCK_BYTE1  = 8'hAA;
  localparam logic [DATA_W-1:0] UNLOCK_BYTE2  = 8'h55;

  // Command bytes
  localparam logic [DATA_W-1:0] CMD_ID      = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ERASE   = 8'h80;
  localparam logic [DATA_W-1:0] CMD_RESET   = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_PROGRAM = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_BANK    = 8'hB0;
  localparam logic [DATA_W-1:0] CMD_SECTOR  = 8'h30;
  localparam logic [DATA_W-1:0] CMD_CHIP    = 8'h10;

  // Data values
  localparam logic [DATA_W-1:0] ERASE_BYTE  = 8'h00;
  localparam logic [DATA_W-1:0] BLANK_BYTE  = 8'hFF;
  localparam logic [DATA_W-1:0] ERASED_READ = 8'hFF;
  localparam logic [DATA_W-1:0] ID_NONE     = 8'h00;
  localparam logic [7:0]        ID_MFR_OFFSET = 8'h00;
  localparam logic [7:0]        ID_DEV_OFFSET = 8'h01;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MFR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV  = 2'd2;

  // Decoded action of one request
  typedef struct packed {
    logic              prog_byte;
    logic              sector_erase;
    logic              chip_erase;
    logic              rd_array;
    logic [DATA_W-1:0] rd_const;
  } cmd_act_t;

endpackage

FILE: hdl/fci_array.sv
// ----------------------------------------------------------------------------
// Flash array storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fci_array import fci_pkg::*; #(
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fci_cmd.sv
// ----------------------------------------------------------------------------
// Flash command decoder
// Holds command phase, read mode and active bank; decodes each request.
// ----------------------------------------------------------------------------
module fci_cmd import fci_pkg::*; #(
  parameter int NUM_BANKS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              wr,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] data,
  input  logic              size_is_128k,
  input  logic [DATA_W-1:0] mfr_id,
  input  logic [DATA_W-1:0] dev_id,
  output cmd_act_t          act,
  output logic              bank_sel
);

  phase_t phase_r, phase_nxt;
  rmode_t mode_r, mode_nxt;
  logic   bank_r, bank_nxt;

  // decode the request against the current phase and mode
  always_comb begin
    phase_nxt    = phase_r;
    mode_nxt     = mode_r;
    bank_nxt     = bank_r;
    act          = '0;
    act.rd_const = ID_NONE;
    if (!wr) begin
      case (mode_r)
        RM_ARRAY: act.rd_array = 1'b1;
        RM_ID: begin
          if (addr[7:0] == ID_MFR_OFFSET) begin
            act.rd_const = mfr_id;
          end else if (addr[7:0] == ID_DEV_OFFSET) begin
            act.rd_const = dev_id;
          end
        end
        RM_ERASED: begin
          act.rd_const = ERASED_READ;
          phase_nxt    = PH_IDLE;
          mode_nxt     = RM_ARRAY;
        end
        default: act.rd_const = ID_NONE;
      endcase
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (addr == UNLOCK_ADDR1 && data == UNLOCK_BYTE1) begin
            phase_nxt = PH_UNLOCK1;
          end
        end
        PH_UNLOCK1: begin
          if (addr == UNLOCK_ADDR2 && data == UNLOCK_BYTE2) begin
            phase_nxt = PH_UNLOCK2;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_UNLOCK2: begin
          if (addr != UNLOCK_ADDR1) begin
            phase_nxt = PH_IDLE;
            mode_nxt  = RM_ARRAY;
          end else if (data == CMD_ID) begin
            phase_nxt = PH_ID;
            mode_nxt  = RM_ID;
          end else if (data == CMD_ERASE) begin
            phase_nxt = PH_ERASE1;
          end else if (data == CMD_PROGRAM) begin
            phase_nxt = PH_PROGRAM;
          end else if (data == CMD_BANK && size_is_128k) begin
            phase_nxt = PH_BANK;
          end else begin
            phase_nxt = PH_IDLE;
            mode_nxt  = RM_ARRAY;
          end
        end
        PH_ERASE1: begin
          if (addr == UNLOCK_ADDR1 && data == UNLOCK_BYTE1) begin
            phase_nxt = PH_ERASE2;
          end else begin
            phase_nxt = PH_IDLE;
            mode_nxt  = RM_ARRAY;
          end
        end
        PH_ERASE2: begin
          if (addr == UNLOCK_ADDR2 && data == UNLOCK_BYTE2) begin
            phase_nxt = PH_ERASE3;
          end else begin
            phase_nxt = PH_IDLE;
            mode_nxt  = RM_ARRAY;
          end
        end
        PH_ERASE3: begin
          // phase holds at confirm until the next read or a write that is no confirm byte
          if (data == CMD_SECTOR) begin
            act.sector_erase = 1'b1;
            mode_nxt         = RM_ERASED;
          end else if (data == CMD_CHIP) begin
            act.chip_erase = 1'b1;
            mode_nxt       = RM_ERASED;
          end else begin
            phase_nxt = PH_IDLE;
            mode_nxt  = RM_ARRAY;
          end
        end
        PH_ID: begin
          if (data == CMD_RESET) begin
            phase_nxt = PH_IDLE;
            mode_nxt  = RM_ARRAY;
          end else if (addr == UNLOCK_ADDR1 && data == UNLOCK_BYTE1) begin
            phase_nxt = PH_UNLOCK1;
          end else begin
            phase_nxt = PH_IDLE;
            mode_nxt  = RM_ARRAY;
          end
        end
        PH_PROGRAM: begin
          act.prog_byte = 1'b1;
          phase_nxt     = PH_IDLE;
          mode_nxt      = RM_ARRAY;
        end
        PH_BANK: begin
          if (addr == BANK_SEL_ADDR) begin
            bank_nxt = (NUM_BANKS > 1) ? data[0] : 1'b0;
          end
          phase_nxt = PH_IDLE;
          mode_nxt  = RM_ARRAY;
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // advance on each executed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mode_r  <= RM_ARRAY;
      bank_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      bank_r  <= bank_nxt;
    end
  end

  assign bank_sel = bank_r;

endmodule

FILE: hdl/flash_command_interface.sv
// ----------------------------------------------------------------------------
// Flash command interface
// Byte-wide flash with unlock/command sequencing, program, sector and chip
// erase, ID readout and bank select; data kept in one on-chip array.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | in_req_type, in_bus_address, in_write_byte
//  out     | out_valid/out_stall| out_read_byte (one per read request)
//  cfg     | cfg_we             | cfg_index, cfg_wdata
//
//  A write request runs in ST_EXEC; a read goes on to ST_RESP (array read data is registered).
//  Sector erase passes ST_SECT_Q and ST_SECT_SET, then clears one byte per cycle
//  (4096 bytes by default); chip erase clears one byte per cycle of the cleared banks.
//  After reset a clearing pass writes FF to all NUM_BANKS*BANK_BYTES bytes
//  (131072 by default), one per cycle, with in_stall high.
//  A result waits in the output register; a new request is taken meanwhile,
//  and a later read holds until that result is taken.
`include "flash_command_interface_defines.svh"

module flash_command_interface import fci_pkg::*; #(
  parameter int BANK_BYTES   = 65536,
  parameter int SECTOR_BYTES = 4096,
  parameter int NUM_BANKS    = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [ADDR_W-1:0]    in_bus_address,
  input  logic [DATA_W-1:0]    in_write_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DATA_W-1:0]    out_read_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int STORE_BYTES = NUM_BANKS * BANK_BYTES;
  localparam int MAW         = $clog2(STORE_BYTES);
  localparam int OW          = $clog2(BANK_BYTES);

  // offset in bank by reciprocal multiply: floor(a/BANK) = (a*M) >> SH
  localparam int     BANK_SH = ADDR_W + OW;
  localparam longint BANK_M  = ((longint'(1) << BANK_SH) + BANK_BYTES - 1) / BANK_BYTES;
  localparam int     PW      = 2 * ADDR_W + 1;
  localparam int     QMAX    = (2 ** ADDR_W - 1) / BANK_BYTES;
  localparam int     QW      = (QMAX > 0) ? $clog2(QMAX + 1) : 1;

  // sector start in the same way; a sector wider than a bank is the bank
  localparam int     SECT_DIV = (SECTOR_BYTES < BANK_BYTES) ? SECTOR_BYTES : BANK_BYTES;
  localparam int     SECT_L   = $clog2(SECT_DIV);
  localparam int     SECT_SH  = OW + SECT_L;
  localparam longint SECT_M   = ((longint'(1) << SECT_SH) + SECT_DIV - 1) / SECT_DIV;
  localparam int     SPW      = 2 * OW + 1;
  localparam int     SQMAX    = (BANK_BYTES - 1) / SECT_DIV;
  localparam int     SQW      = (SQMAX > 0) ? $clog2(SQMAX + 1) : 1;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EXEC     = 6'b000010,
    ST_RESP     = 6'b000100,
    ST_SECT_Q   = 6'b001000,
    ST_SECT_SET = 6'b010000,
    ST_SWEEP    = 6'b100000
  } seq_t;

  seq_t state_r, state_nxt;

  // configuration registers
  logic              size_r;
  logic [DATA_W-1:0] mfr_r;
  logic [DATA_W-1:0] dev_r;

  // captured request
  logic              req_wr_r;
  logic [ADDR_W-1:0] req_addr_r;
  logic [DATA_W-1:0] req_data_r;
  logic [QW-1:0]     req_q_r;

  // read result pending
  logic              rd_array_r, rd_array_nxt;
  logic [DATA_W-1:0] rd_const_r, rd_const_nxt;

  // erase sweep
  logic [MAW-1:0]    ptr_r, ptr_nxt;
  logic [MAW-1:0]    last_r, last_nxt;
  logic [DATA_W-1:0] fill_r, fill_nxt;
  logic [OW-1:0]     off_r, off_nxt;
  logic [SQW-1:0]    sect_q_r, sect_q_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  logic              in_accept;
  logic [PW-1:0]     bank_prod;
  logic [SPW-1:0]    sect_prod;
  logic [ADDR_W-1:0] off_full;
  logic [OW-1:0]     exec_off;
  logic [MAW-1:0]    bank_base;
  logic [MAW-1:0]    exec_addr;
  logic [OW-1:0]     sect_start;
  logic [OW:0]       sect_end;
  logic [OW-1:0]     sect_last;
  logic              bank_sel;
  cmd_act_t          act;

  logic              mem_we;
  logic [MAW-1:0]    mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [DATA_W-1:0] mem_rdata;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 1'b0;
      mfr_r  <= 8'd50;
      dev_r  <= 8'd27;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE: size_r <= cfg_wdata[0];
        CFG_MFR:  mfr_r  <= cfg_wdata;
        CFG_DEV:  dev_r  <= cfg_wdata;
        default:  size_r <= size_r;
      endcase
    end
  end

  // bank quotient of the incoming address
  assign bank_prod = PW'(in_bus_address) * PW'(BANK_M);

  // capture the request
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_wr_r   <= in_req_type;
      req_addr_r <= in_bus_address;
      req_data_r <= in_write_byte;
      req_q_r    <= bank_prod[BANK_SH +: QW];
    end
  end

  // array address of the request
  assign off_full  = ADDR_W'(req_addr_r - ADDR_W'(ADDR_W'(req_q_r) * ADDR_W'(BANK_BYTES)));
  assign exec_off  = off_full[OW-1:0];
  assign bank_base = bank_sel ? MAW'(BANK_BYTES) : '0;
  assign exec_addr = bank_base + MAW'(exec_off);

  // sector bounds
  assign sect_prod  = SPW'(off_r) * SPW'(SECT_M);
  assign sect_start = OW'((OW + 1)'(sect_q_r) * (OW + 1)'(SECT_DIV));

  always_comb begin
    sect_end = {1'b0, sect_start} + (OW + 1)'(SECT_DIV);
    if (sect_end > (OW + 1)'(BANK_BYTES)) begin
      sect_end = (OW + 1)'(BANK_BYTES);
    end
    sect_last = OW'(sect_end - (OW + 1)'(1));
  end

  fci_cmd #(
    .NUM_BANKS (NUM_BANKS)
  ) u_cmd (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (state_r == ST_EXEC),
    .wr           (req_wr_r),
    .addr         (req_addr_r),
    .data         (req_data_r),
    .size_is_128k (size_r),
    .mfr_id       (mfr_r),
    .dev_id       (dev_r),
    .act          (act),
    .bank_sel     (bank_sel)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_array_nxt  = rd_array_r;
    rd_const_nxt  = rd_const_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    fill_nxt      = fill_r;
    off_nxt       = off_r;
    sect_q_nxt    = sect_q_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = fill_r;
    mem_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        off_nxt = exec_off;
        if (!req_wr_r) begin
          mem_re       = act.rd_array;
          rd_array_nxt = act.rd_array;
          rd_const_nxt = act.rd_const;
          state_nxt    = ST_RESP;
        end else if (act.prog_byte) begin
          mem_we    = 1'b1;
          mem_waddr = exec_addr;
          mem_wdata = req_data_r;
          state_nxt = ST_IDLE;
        end else if (act.sector_erase) begin
          state_nxt = ST_SECT_Q;
        end else if (act.chip_erase) begin
          ptr_nxt   = '0;
          last_nxt  = size_r ? MAW'(STORE_BYTES - 1) : MAW'(BANK_BYTES - 1);
          fill_nxt  = ERASE_BYTE;
          state_nxt = ST_SWEEP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        // hold while the previous result still waits
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_array_r ? mem_rdata : rd_const_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SECT_Q: begin
        sect_q_nxt = sect_prod[SECT_SH +: SQW];
        state_nxt  = ST_SECT_SET;
      end
      ST_SECT_SET: begin
        ptr_nxt   = bank_base + MAW'(sect_start);
        last_nxt  = bank_base + MAW'(sect_last);
        fill_nxt  = ERASE_BYTE;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (ptr_r == last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + MAW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      ptr_r       <= '0;
      last_r      <= MAW'(STORE_BYTES - 1);
      fill_r      <= BLANK_BYTE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      last_r      <= last_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_array_r <= rd_array_nxt;
    rd_const_r <= rd_const_nxt;
    off_r      <= off_nxt;
    sect_q_r   <= sect_q_nxt;
    out_data_r <= out_data_nxt;
  end

  fci_array #(
    .DEPTH (STORE_BYTES)
  ) u_array (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (exec_addr),
    .rdata (mem_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_data_r;

  // checks
  `FCI_ASSERT_NEXT(a_accept_exec, in_accept, state_r == ST_EXEC, "request not executed")
  `FCI_ASSERT_SAME(a_sweep_bound, state_r == ST_SWEEP, ptr_r <= last_r, "sweep past end")
  `FCI_ASSERT_NEXT(a_out_from_resp, !out_valid_r && state_r != ST_RESP, !out_valid_r,
                   "result without read")
  `FCI_ASSERT_SAME(a_no_write_idle, state_r == ST_IDLE || state_r == ST_RESP, !mem_we,
                   "array write while idle")

endmodule
